[design/dbb_pkg.sv]
package dbb_pkg;

    // Fixed field widths of the block's ports and registers.
    localparam int FRAME_BITS     = 12;
    localparam int DECAY_BITS     = 16;
    localparam int LEVEL_IN_BITS  = 16;
    localparam int OUT_LEVEL_BITS = 16;
    localparam int POS_BITS       = 11;
    localparam int ROW_BITS       = 12;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Grid limits that do not follow a module parameter.
    localparam logic [ROW_BITS-1:0]   MAX_HEIGHT = 12'd2048;
    localparam logic [FRAME_BITS-1:0] MIN_DIM    = 12'd3;

    // Register values after reset.
    localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = 12'd1920;
    localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = 12'd1080;
    localparam logic [DECAY_BITS-1:0] DECAY_AMOUNT_RESET = 16'd5;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } action_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_DECAY_AMOUNT = 2'd2
    } cfg_reg_t;

    // Per-item decision made by the position tracker when the item is taken.
    typedef struct packed {
        logic                emit;
        logic                last;
        logic                top_ok;
        logic                bot_ok;
        logic                left_ok;
        logic                right_ok;
        logic                use_level;
        logic [POS_BITS-1:0] col;
        logic [POS_BITS-1:0] row;
    } pos_info_t;

endpackage

[design/dbb_track.sv]
module dbb_track #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                action,
    input  logic [dbb_pkg::FRAME_BITS-1:0]      frame_width,
    input  logic [dbb_pkg::FRAME_BITS-1:0]      frame_height,
    output logic [$clog2(MAX_WIDTH)-1:0]        col,
    output dbb_pkg::pos_info_t                  info
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = CW + 1;
    localparam int FWW = (WW > dbb_pkg::FRAME_BITS) ? WW : dbb_pkg::FRAME_BITS;
    localparam int CXW = (CW > dbb_pkg::POS_BITS) ? CW : dbb_pkg::POS_BITS;
    localparam int RW  = dbb_pkg::ROW_BITS;

    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_reg;
    logic [RW-1:0]  row_next;
    logic [FWW-1:0] fw_x;
    logic [FWW-1:0] w_clamp;
    logic [WW-1:0]  w_eff;
    logic [WW-1:0]  wm1;
    logic [RW-1:0]  h_eff;
    logic           off_grid;
    logic [CW-1:0]  c;
    logic [RW-1:0]  r;
    logic [WW-1:0]  c_inc;
    logic           cand;
    logic [RW-1:0]  rc;
    logic [CW-1:0]  cc;
    logic [CXW-1:0] cc_x;

    always_comb
    begin
        fw_x = FWW'(frame_width);
        if (fw_x < FWW'(dbb_pkg::MIN_DIM))
        begin
            w_clamp = FWW'(dbb_pkg::MIN_DIM);
        end
        else if (fw_x > FWW'(MAX_WIDTH))
        begin
            w_clamp = FWW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = fw_x;
        end
        w_eff = w_clamp[WW-1:0];
        wm1   = w_eff - WW'(1);

        if (frame_height < dbb_pkg::MIN_DIM)
        begin
            h_eff = dbb_pkg::MIN_DIM;
        end
        else if (frame_height > dbb_pkg::MAX_HEIGHT)
        begin
            h_eff = dbb_pkg::MAX_HEIGHT;
        end
        else
        begin
            h_eff = frame_height;
        end

        // A register change can leave the stored position outside the grid;
        // the item then opens a new frame.
        off_grid = ({1'b0, col_reg} >= w_eff) || (row_reg > h_eff + RW'(1));
        c = off_grid ? '0 : col_reg;
        r = off_grid ? '0 : row_reg;
        c_inc = {1'b0, c} + WW'(1);

        // The centre cell is one row up and one column left of the arrival,
        // wrapping to the end of the row before last at the start of a row.
        if ((c != '0) && (r != '0))
        begin
            cand = 1'b1;
            rc   = r - RW'(1);
            cc   = c - CW'(1);
        end
        else if ((c == '0) && (r >= RW'(2)))
        begin
            cand = 1'b1;
            rc   = r - RW'(2);
            cc   = wm1[CW-1:0];
        end
        else
        begin
            cand = 1'b0;
            rc   = '0;
            cc   = '0;
        end

        cc_x = CXW'(cc);
        info.emit      = cand && (rc < h_eff);
        info.last      = info.emit && (rc == h_eff - RW'(1)) && ({1'b0, cc} == wm1);
        info.top_ok    = (rc != '0);
        info.bot_ok    = (rc < h_eff - RW'(1));
        info.left_ok   = (cc != '0);
        info.right_ok  = ({1'b0, cc} < wm1);
        info.use_level = (r < h_eff) && (dbb_pkg::action_t'(action) == dbb_pkg::ACT_PIXEL);
        info.col       = cc_x[dbb_pkg::POS_BITS-1:0];
        info.row       = rc[dbb_pkg::POS_BITS-1:0];

        if (info.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (c_inc >= w_eff)
        begin
            col_next = '0;
            row_next = r + RW'(1);
        end
        else
        begin
            col_next = c_inc[CW-1:0];
            row_next = r;
        end

        col = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_last_restarts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && info.last) |=> ((col_reg == '0) && (row_reg == '0)))
        else $error("position did not return to the frame start after the last cell");

    a_last_is_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        info.last |-> (info.emit && info.right_ok == 1'b0 && info.bot_ok == 1'b0))
        else $error("frame end flagged on a cell that is not the bottom-right one");

endmodule

[design/decay_and_box_blur_3x3_core.sv]
// Streaming 3x3 box blur with decay.
// Input channel (in_valid, in_stall, action, level): one grid level per transfer in
// raster order; a flush item (action high) stands in for a zero level, and
// frame_width + 1 flush items after the last pixel drain the final row.
// Output channel (out_valid, out_stall, blurred_level, out_col, out_row, frame_last):
// one transfer per centre cell, in raster order, frame_last marking the bottom-right cell.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; index 0 is frame_width, 1 frame_height, 2 decay_amount, others ignored.
// The user must write registers only while no item is in flight; the block does not enforce it.
// Throughput is one item per clock while no stalled receiver has filled the pipeline:
// each line store takes one read and one write per item. The item that completes a
// neighbourhood goes through the input stage with line store read, the adder stage and the divide stage.
// When out_stall is high a valid output holds, and in_stall rises only once every stage
// is full, so up to three items are absorbed behind a stalled receiver.
// Reset clears position, window and pipeline and restores the register defaults. The
// line stores are not cleared; a fill count makes columns never written read as zero.
module decay_and_box_blur_3x3_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int LEVEL_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic [dbb_pkg::LEVEL_IN_BITS-1:0]     level,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [dbb_pkg::OUT_LEVEL_BITS-1:0]    blurred_level,
    output logic [dbb_pkg::POS_BITS-1:0]          out_col,
    output logic [dbb_pkg::POS_BITS-1:0]          out_row,
    output logic                                  frame_last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dbb_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [dbb_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    // Column index width, stored level width, nine-term sum width, and the
    // reciprocal used for the exact division by nine: with a shift of
    // four bits beyond the sum width the rounding error of ceil(2^s/9)
    // stays below one for every sum.
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int DW   = (LEVEL_BITS < dbb_pkg::LEVEL_IN_BITS) ? LEVEL_BITS
                                                                : dbb_pkg::LEVEL_IN_BITS;
    localparam int SW   = DW + 4;
    localparam int DIVS = SW + 4;
    localparam int MW   = DIVS - 2;
    localparam int PW   = SW + MW;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << DIVS) + 64'd8) / 64'd9);

    // Configuration registers.
    logic [dbb_pkg::FRAME_BITS-1:0] frame_width_reg;
    logic [dbb_pkg::FRAME_BITS-1:0] frame_height_reg;
    logic [dbb_pkg::DECAY_BITS-1:0] decay_amount_reg;

    // Handshake and pipeline control.
    logic accept;
    logic out_go;
    logic s2_free;
    logic s1_free;
    logic s1_adv;

    // Position tracker outputs for the item at the input.
    logic [CW-1:0]       trk_col;
    dbb_pkg::pos_info_t  trk_info;
    logic [DW-1:0]       d_in;
    logic [dbb_pkg::LEVEL_IN_BITS-1:0] lv16;

    // Stage 1: decayed level, line store read data and forwarding.
    logic               s1_v_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [DW-1:0]      s1_d_reg;
    dbb_pkg::pos_info_t s1_info_reg;
    logic [DW-1:0]      rd_up_reg;
    logic [DW-1:0]      rd_mid_reg;
    logic               byp_reg;
    logic [DW-1:0]      byp_up_reg;
    logic [DW-1:0]      byp_mid_reg;
    logic               rd_ok_reg;
    logic [DW-1:0]      up_eff;
    logic [DW-1:0]      mid_eff;

    // Line stores and their fill count.
    logic [DW-1:0] upper_mem  [MAX_WIDTH];
    logic [DW-1:0] middle_mem [MAX_WIDTH];
    logic [CW:0]   hwm_reg;

    // 3x3 window, newest column at positions 2, 5 and 8.
    logic [DW-1:0] win_reg [9];
    logic [DW-1:0] win_new [9];
    logic [SW-1:0] term    [9];
    logic [2:0]    row_en;
    logic [2:0]    col_en;
    logic [SW-1:0] sum;

    // Stage 2: neighbourhood sum.
    logic                         s2_v_reg;
    logic [SW-1:0]                s2_sum_reg;
    logic [dbb_pkg::POS_BITS-1:0] s2_col_reg;
    logic [dbb_pkg::POS_BITS-1:0] s2_row_reg;
    logic                         s2_last_reg;
    logic [PW-1:0]                prod;

    // Output register.
    logic                                out_v_reg;
    logic [dbb_pkg::OUT_LEVEL_BITS-1:0]  out_level_reg;
    logic [dbb_pkg::POS_BITS-1:0]        out_col_reg;
    logic [dbb_pkg::POS_BITS-1:0]        out_row_reg;
    logic                                out_last_reg;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= dbb_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= dbb_pkg::FRAME_HEIGHT_RESET;
            decay_amount_reg <= dbb_pkg::DECAY_AMOUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dbb_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= cfg_data[dbb_pkg::FRAME_BITS-1:0];
                end
                dbb_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= cfg_data[dbb_pkg::FRAME_BITS-1:0];
                end
                dbb_pkg::REG_DECAY_AMOUNT:
                begin
                    decay_amount_reg <= cfg_data[dbb_pkg::DECAY_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Each stage moves on when the stage after it is empty or moving, so a
    // stalled receiver backs the pipeline up one stage at a time.
    always_comb
    begin
        out_go   = !out_v_reg || !out_stall;
        s2_free  = !s2_v_reg || out_go;
        s1_adv   = s1_v_reg && s2_free;
        s1_free  = !s1_v_reg || s2_free;
        in_stall = !s1_free;
        accept   = in_valid && !in_stall;
    end

    dbb_track #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .action       (action),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .col          (trk_col),
        .info         (trk_info)
    );

    // Decay, clamped at zero. Flush items and late pixels enter as zero.
    always_comb
    begin
        lv16 = dbb_pkg::LEVEL_IN_BITS'(level[DW-1:0]);
        if (trk_info.use_level && (lv16 > decay_amount_reg))
        begin
            d_in = DW'(lv16 - decay_amount_reg);
        end
        else
        begin
            d_in = '0;
        end
    end

    // The line stores are written as the item leaves stage 1 and read as
    // the next item enters. Right after a frame end both touch column zero
    // in the same cycle, so that case is forwarded around the store.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            upper_mem[s1_col_reg]  <= mid_eff;
            middle_mem[s1_col_reg] <= s1_d_reg;
        end
        if (accept)
        begin
            rd_up_reg  <= upper_mem[trk_col];
            rd_mid_reg <= middle_mem[trk_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= trk_col;
            s1_d_reg    <= d_in;
            s1_info_reg <= trk_info;
            byp_reg     <= s1_adv && (s1_col_reg == trk_col);
            byp_up_reg  <= mid_eff;
            byp_mid_reg <= s1_d_reg;
            rd_ok_reg   <= ({1'b0, trk_col} < hwm_reg);
        end
    end

    // Columns are always visited from zero upward, so the columns written
    // since reset form a prefix below the fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hwm_reg <= '0;
        end
        else if (s1_adv && ({1'b0, s1_col_reg} >= hwm_reg))
        begin
            hwm_reg <= {1'b0, s1_col_reg} + (CW+1)'(1);
        end
    end

    always_comb
    begin
        if (byp_reg)
        begin
            up_eff  = byp_up_reg;
            mid_eff = byp_mid_reg;
        end
        else if (rd_ok_reg)
        begin
            up_eff  = rd_up_reg;
            mid_eff = rd_mid_reg;
        end
        else
        begin
            up_eff  = '0;
            mid_eff = '0;
        end
    end

    // Window shift and masked sum. Rows and columns that fall outside the
    // grid drop out of the sum, whatever the window still holds there.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_new[k*3 + 0] = win_reg[k*3 + 1];
            win_new[k*3 + 1] = win_reg[k*3 + 2];
        end
        win_new[2] = up_eff;
        win_new[5] = mid_eff;
        win_new[8] = s1_d_reg;

        row_en = {s1_info_reg.bot_ok, 1'b1, s1_info_reg.top_ok};
        col_en = {s1_info_reg.right_ok, 1'b1, s1_info_reg.left_ok};
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                term[k*3 + j] = (row_en[k] && col_en[j]) ? SW'(win_new[k*3 + j]) : '0;
            end
        end
        sum = term[0] + term[1] + term[2] + term[3] + term[4]
            + term[5] + term[6] + term[7] + term[8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_new[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_info_reg.emit)
        begin
            s2_sum_reg  <= sum;
            s2_col_reg  <= s1_info_reg.col;
            s2_row_reg  <= s1_info_reg.row;
            s2_last_reg <= s1_info_reg.last;
        end
    end

    // Truncating division by nine as a multiply by the reciprocal.
    assign prod = PW'(s2_sum_reg) * PW'(RECIP);

    always_ff @(posedge clk)
    begin
        if (out_go && s2_v_reg)
        begin
            out_level_reg <= dbb_pkg::OUT_LEVEL_BITS'(prod[DIVS +: DW]);
            out_col_reg   <= s2_col_reg;
            out_row_reg   <= s2_row_reg;
            out_last_reg  <= s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_v_reg <= accept;
            end
            if (s2_free)
            begin
                s2_v_reg <= s1_adv && s1_info_reg.emit;
            end
            if (out_go)
            begin
                out_v_reg <= s2_v_reg;
            end
        end
    end

    assign out_valid     = out_v_reg;
    assign blurred_level = out_level_reg;
    assign out_col       = out_col_reg;
    assign out_row       = out_row_reg;
    assign frame_last    = out_last_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_v_reg && s2_v_reg && out_v_reg && out_stall))
        else $error("input stalled while the pipeline had room");

    a_fill_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        hwm_reg <= (CW+1)'(MAX_WIDTH))
        else $error("line store fill count ran past the store depth");

    a_emit_reaches_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_info_reg.emit) |=> s2_v_reg)
        else $error("a centre cell left stage 1 without reaching the sum stage");

endmodule

[tb/decay_and_box_blur_3x3_core_tb.sv]
module decay_and_box_blur_3x3_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Line store depth of the block as built (its MAX_WIDTH default).
    localparam int STORE_DEPTH = 2048;
    // Pixels sent under the reset geometry; far fewer than one 1920-wide row.
    localparam int RESET_ITEMS = 20;
    // Items of the widest and of the tallest grid before those frames are cut.
    localparam int unsigned WIDE_CUT = 150;
    localparam int unsigned TALL_CUT = 200;
    // Random stimulus stops after this many items; with the fixed tests the run sends
    // about 1300 items in all.
    localparam int unsigned RANDOM_ITEMS = 900;
    // Margin waited after the last predicted result before a register write, so that no
    // item is left in flight.
    localparam int DRAIN_CYCLES = 8;
    // Cycles without any transfer on any channel before the run is declared hung.
    localparam int IDLE_LIMIT = 5000;
    // The index that no register answers to; writes there must change nothing.
    localparam logic [dbb_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    // One blurred cell as it should leave the block.
    typedef struct {
        logic [dbb_pkg::OUT_LEVEL_BITS-1:0] blurred;
        logic [dbb_pkg::POS_BITS-1:0]       col;
        logic [dbb_pkg::POS_BITS-1:0]       row;
        logic                               last;
    } blur_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic                               action = dbb_pkg::ACT_PIXEL;
    logic [dbb_pkg::LEVEL_IN_BITS-1:0]  level = '0;

    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [dbb_pkg::OUT_LEVEL_BITS-1:0] blurred_level;
    logic [dbb_pkg::POS_BITS-1:0]       out_col;
    logic [dbb_pkg::POS_BITS-1:0]       out_row;
    logic                               frame_last;

    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [dbb_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [dbb_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    // Shadow copy of the block's registers, as written through the configuration channel.
    logic [dbb_pkg::FRAME_BITS-1:0] cfg_width  = dbb_pkg::FRAME_WIDTH_RESET;
    logic [dbb_pkg::FRAME_BITS-1:0] cfg_height = dbb_pkg::FRAME_HEIGHT_RESET;
    logic [dbb_pkg::DECAY_BITS-1:0] cfg_decay  = dbb_pkg::DECAY_AMOUNT_RESET;

    // Shadow of the block's datapath state: the two line stores hold decayed levels of
    // the two rows above the incoming one, the window holds the 3x3 neighborhood with
    // index row * 3 + col, and the counters track the stream position.
    logic [dbb_pkg::LEVEL_IN_BITS-1:0] store_upper [0:STORE_DEPTH-1] = '{default: '0};
    logic [dbb_pkg::LEVEL_IN_BITS-1:0] store_middle [0:STORE_DEPTH-1] = '{default: '0};
    logic [dbb_pkg::LEVEL_IN_BITS-1:0] window [0:8] = '{default: '0};
    int unsigned pos_col = 0;
    int unsigned pos_row = 0;
    int unsigned overrun_count = 0;

    // Set by the predictor when the bottom-right cell of a frame has been produced.
    bit frame_closed = 1'b0;

    // Blurred cells predicted but not yet seen on the output, oldest first.
    blur_result_t pending_blurs [$];
    blur_result_t oldest;
    int fail_count = 0;

    // Sender pacing: transfers come in bursts, and gaps between bursts only when enabled.
    bit gaps_on = 1'b0;
    int unsigned burst_left = 0;

    // Receiver stall pattern: a style (none, light, heavy) that changes at random intervals,
    // and within it stall levels held for random runs.
    int unsigned stall_style = 0;
    int unsigned style_timer = 0;
    int unsigned stall_hold = 0;

    int unsigned idle_cycles = 0;

    decay_and_box_blur_3x3_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .level         (level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .blurred_level (blurred_level),
        .out_col       (out_col),
        .out_row       (out_row),
        .frame_last    (frame_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // The grid dimensions the block actually uses: register values are clamped to at
    // least three, and to the line store depth or the height limit at the top.
    function automatic int unsigned used_width();
        if (cfg_width < dbb_pkg::MIN_DIM) return dbb_pkg::MIN_DIM;
        if (cfg_width > STORE_DEPTH) return STORE_DEPTH;
        return cfg_width;
    endfunction

    function automatic int unsigned used_height();
        if (cfg_height < dbb_pkg::MIN_DIM) return dbb_pkg::MIN_DIM;
        if (cfg_height > dbb_pkg::MAX_HEIGHT) return dbb_pkg::MAX_HEIGHT;
        return cfg_height;
    endfunction

    // True when the next item lands on a grid row, so that a pixel there is blurred.
    // A position left beyond the grid by a register change starts over at the origin.
    function automatic bit next_in_grid();
        int unsigned w;
        int unsigned h;
        w = used_width();
        h = used_height();
        if (pos_col >= w || pos_row > h + 1) return 1'b1;
        return pos_row < h;
    endfunction

    // Advances the shadow state by one accepted item and reports whether it completes
    // the neighborhood of a centre cell; if so, the blurred cell is returned in res.
    function automatic bit predict_blur(input dbb_pkg::action_t act,
                                        input logic [dbb_pkg::LEVEL_IN_BITS-1:0] lvl,
                                        output blur_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned rc;
        int unsigned cc;
        int unsigned sum;
        logic [dbb_pkg::LEVEL_IN_BITS-1:0] fresh;
        logic [dbb_pkg::LEVEL_IN_BITS-1:0] upper_cell;
        logic [dbb_pkg::LEVEL_IN_BITS-1:0] middle_cell;
        bit emit;

        w = used_width();
        h = used_height();
        c = pos_col;
        r = pos_row;
        rc = 0;
        cc = 0;
        fresh = '0;
        emit = 1'b0;
        res = '{default: '0};

        // A register change may leave the position outside the grid in use.
        if (c >= w || r > h + 1) begin
            c = 0;
            r = 0;
            overrun_count = 0;
        end

        // Only pixels on grid rows carry a level; flushes and late pixels add zero.
        if (r < h) begin
            if (act == dbb_pkg::ACT_PIXEL) fresh = (lvl > cfg_decay) ? lvl - cfg_decay : '0;
        end else if (overrun_count < 4095) begin
            overrun_count++;
        end

        upper_cell = store_upper[c];
        middle_cell = store_middle[c];
        store_upper[c] = middle_cell;
        store_middle[c] = fresh;

        for (int k = 0; k < 3; k++) begin
            window[k * 3 + 0] = window[k * 3 + 1];
            window[k * 3 + 1] = window[k * 3 + 2];
        end
        window[2] = upper_cell;
        window[5] = middle_cell;
        window[8] = fresh;

        // The centre sits one row up and one column left of the item; on column zero
        // it is the last column of the row before.
        if (c >= 1 && r >= 1) begin
            rc = r - 1;
            cc = c - 1;
            emit = 1'b1;
        end else if (c == 0 && r >= 2) begin
            rc = r - 2;
            cc = w - 1;
            emit = 1'b1;
        end
        if (emit && rc >= h) emit = 1'b0;

        if (emit) begin
            sum = 0;
            // Neighbors outside the grid count as zero whatever the stores hold.
            for (int wr = 0; wr < 3; wr++) begin
                if (wr == 0 && rc == 0) continue;
                if (wr == 2 && rc + 1 >= h) continue;
                for (int wc = 0; wc < 3; wc++) begin
                    if (wc == 0 && cc == 0) continue;
                    if (wc == 2 && cc + 1 >= w) continue;
                    sum += window[wr * 3 + wc];
                end
            end
            res.blurred = dbb_pkg::OUT_LEVEL_BITS'(sum / 9);
            res.col = dbb_pkg::POS_BITS'(cc);
            res.row = dbb_pkg::POS_BITS'(rc);
            res.last = (rc == h - 1) && (cc == w - 1);
            if (res.last) begin
                pos_col = 0;
                pos_row = 0;
                overrun_count = 0;
                frame_closed = 1'b1;
                return 1'b1;
            end
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        pos_col = c;
        pos_row = r;
        return emit;
    endfunction

    // Presents one item, holds it until the block takes it, then records the
    // predicted result. Valid stays high into the next item unless a gap follows.
    task automatic send_item(input dbb_pkg::action_t act,
                             input logic [dbb_pkg::LEVEL_IN_BITS-1:0] lvl);
        blur_result_t res;
        in_valid <= 1'b1;
        action <= act;
        level <= lvl;
        do @(posedge clk); while (in_stall);
        if (predict_blur(act, lvl, res)) pending_blurs.push_back(res);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            if (gaps_on) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // Writes one register; cfg_valid is left high so that writes can follow back to back.
    task automatic write_reg(input logic [dbb_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [dbb_pkg::CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            dbb_pkg::REG_FRAME_WIDTH:  cfg_width = data[dbb_pkg::FRAME_BITS-1:0];
            dbb_pkg::REG_FRAME_HEIGHT: cfg_height = data[dbb_pkg::FRAME_BITS-1:0];
            dbb_pkg::REG_DECAY_AMOUNT: cfg_decay = data[dbb_pkg::DECAY_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [dbb_pkg::CFG_DATA_BITS-1:0] width_data,
                                input logic [dbb_pkg::CFG_DATA_BITS-1:0] height_data,
                                input logic [dbb_pkg::CFG_DATA_BITS-1:0] decay_data);
        write_reg(dbb_pkg::REG_FRAME_WIDTH, width_data);
        write_reg(dbb_pkg::REG_FRAME_HEIGHT, height_data);
        write_reg(dbb_pkg::REG_DECAY_AMOUNT, decay_data);
        cfg_valid <= 1'b0;
    endtask

    // Stops sending and waits for every outstanding blurred cell, plus a margin for a
    // last item that completes no neighborhood but may still be in the pipeline.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_blurs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly small grids, some below the clamp, a few wider ones; the upper four bits
    // of the write data are junk that the block must drop.
    function automatic logic [dbb_pkg::CFG_DATA_BITS-1:0] pick_dim();
        int unsigned roll;
        int unsigned dim;
        roll = $urandom_range(0, 99);
        if (roll < 75) dim = $urandom_range(3, 10);
        else if (roll < 90) dim = $urandom_range(0, 2);
        else dim = $urandom_range(11, 40);
        return {4'($urandom), dbb_pkg::FRAME_BITS'(dim)};
    endfunction

    function automatic logic [dbb_pkg::CFG_DATA_BITS-1:0] pick_decay();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return '0;
        if (roll < 50) return dbb_pkg::CFG_DATA_BITS'($urandom_range(1, 255));
        if (roll < 85) return dbb_pkg::CFG_DATA_BITS'($urandom);
        return '1;
    endfunction

    // Sends items until the frame closes, or until cut_at items if that is nonzero.
    // A well-formed frame sends pixels on grid rows and flushes after them, with rare
    // early flushes and some late pixels; a ragged one picks each action at random.
    task automatic run_frame(input int unsigned cut_at, input bit ragged,
                             output int unsigned taken);
        dbb_pkg::action_t act;
        logic [dbb_pkg::LEVEL_IN_BITS-1:0] lvl;
        taken = 0;
        frame_closed = 1'b0;
        while (!frame_closed && (cut_at == 0 || taken < cut_at)) begin
            if (ragged)
                act = ($urandom_range(0, 1) != 0) ? dbb_pkg::ACT_FLUSH : dbb_pkg::ACT_PIXEL;
            else if (next_in_grid())
                act = ($urandom_range(0, 99) < 3) ? dbb_pkg::ACT_FLUSH : dbb_pkg::ACT_PIXEL;
            else
                act = ($urandom_range(0, 99) < 20) ? dbb_pkg::ACT_PIXEL : dbb_pkg::ACT_FLUSH;
            // Levels right around the decay amount probe the clamp at zero.
            if ($urandom_range(0, 9) == 0)
                lvl = cfg_decay + dbb_pkg::LEVEL_IN_BITS'($urandom_range(0, 2)) - 1'b1;
            else
                lvl = dbb_pkg::LEVEL_IN_BITS'($urandom);
            send_item(act, lvl);
            taken++;
        end
    endtask

    // Before any register write the block runs with its reset values: a 1920-wide grid,
    // so a short run of pixels completes no neighborhood and must produce nothing. Width
    // and height are then set to three while the decay keeps its default of five; the
    // position lies beyond the new width, so the frame that follows starts at the origin.
    task automatic test_reset_defaults();
        int unsigned taken;
        gaps_on = 1'b1;
        for (int i = 0; i < RESET_ITEMS; i++) begin
            if ($urandom_range(0, 4) == 0)
                send_item(dbb_pkg::ACT_PIXEL, dbb_pkg::LEVEL_IN_BITS'($urandom_range(0, 10)));
            else
                send_item(dbb_pkg::ACT_PIXEL, dbb_pkg::LEVEL_IN_BITS'($urandom));
        end
        drain_pipeline();
        write_reg(dbb_pkg::REG_FRAME_WIDTH, 16'h0003);
        write_reg(dbb_pkg::REG_FRAME_HEIGHT, 16'h0003);
        cfg_valid <= 1'b0;
        run_frame(0, 1'b0, taken);
    endtask

    // Two hand-made 3x3 frames. The first, without decay, mixes full-scale and zero
    // levels and has an early flush in the centre and a late pixel among the flushes.
    // The second uses a decay of half scale with levels at, just above and just below it.
    task automatic test_directed_cases();
        dbb_pkg::action_t acts [13];
        logic [dbb_pkg::LEVEL_IN_BITS-1:0] lvls [13];

        drain_pipeline();
        write_reg(REG_UNUSED, dbb_pkg::CFG_DATA_BITS'($urandom));
        set_geometry(16'hF003, 16'h3003, 16'h0000);
        gaps_on = 1'b0;
        acts = '{dbb_pkg::ACT_PIXEL, dbb_pkg::ACT_PIXEL, dbb_pkg::ACT_PIXEL,
                 dbb_pkg::ACT_PIXEL, dbb_pkg::ACT_FLUSH, dbb_pkg::ACT_PIXEL,
                 dbb_pkg::ACT_PIXEL, dbb_pkg::ACT_PIXEL, dbb_pkg::ACT_PIXEL,
                 dbb_pkg::ACT_FLUSH, dbb_pkg::ACT_PIXEL, dbb_pkg::ACT_FLUSH,
                 dbb_pkg::ACT_FLUSH};
        lvls = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000,
                 16'h7FFF, 16'hFFFF, 16'h1234, 16'hFFFF, 16'h0000, 16'hFFFF};
        for (int i = 0; i < 13; i++) send_item(acts[i], lvls[i]);

        drain_pipeline();
        set_geometry(16'h0003, 16'h0003, 16'h8000);
        gaps_on = 1'b1;
        acts = '{dbb_pkg::ACT_PIXEL, dbb_pkg::ACT_PIXEL, dbb_pkg::ACT_PIXEL,
                 dbb_pkg::ACT_PIXEL, dbb_pkg::ACT_PIXEL, dbb_pkg::ACT_PIXEL,
                 dbb_pkg::ACT_PIXEL, dbb_pkg::ACT_PIXEL, dbb_pkg::ACT_PIXEL,
                 dbb_pkg::ACT_FLUSH, dbb_pkg::ACT_FLUSH, dbb_pkg::ACT_FLUSH,
                 dbb_pkg::ACT_FLUSH};
        lvls = '{16'hFFFF, 16'h8000, 16'h8001, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h8001,
                 16'hFFFF, 16'h8000, 16'hA5A5, 16'h5A5A, 16'hFFFF, 16'h0000};
        for (int i = 0; i < 13; i++) send_item(acts[i], lvls[i]);
    endtask

    // The widest grid with the fewest rows, then the narrowest with the most rows.
    // Both dimensions are written beyond their clamps. The wide frame is cut well before
    // its first neighborhood completes, so it must produce nothing; the tall one is cut
    // after a few dozen rows of blurred cells.
    task automatic test_size_extremes();
        int unsigned taken;
        drain_pipeline();
        set_geometry(16'hFFFF, 16'h0000, pick_decay());
        gaps_on = 1'b1;
        run_frame(WIDE_CUT, 1'b0, taken);
        drain_pipeline();
        set_geometry(16'h5001, 16'hFFFF, pick_decay());
        gaps_on = 1'b0;
        run_frame(TALL_CUT, 1'b0, taken);
    endtask

    // Random frames with random geometry and decay. Some frames are cut short; a write
    // that follows may then shrink the grid under the current position, or change it
    // mid-frame. Register writes come only after the pipeline has drained, and between
    // them frames run back to back. The last frame is cut where the item budget ends.
    task automatic test_random_frames();
        int unsigned sent_total;
        int unsigned cut_at;
        int unsigned taken;
        sent_total = 0;
        while (sent_total < RANDOM_ITEMS) begin
            if (sent_total == 0 || $urandom_range(0, 99) < 40) begin
                drain_pipeline();
                set_geometry(pick_dim(), pick_dim(), pick_decay());
            end
            gaps_on = $urandom_range(0, 3) != 0;
            cut_at = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 40) : 0;
            if (cut_at == 0 || cut_at > RANDOM_ITEMS - sent_total)
                cut_at = RANDOM_ITEMS - sent_total;
            run_frame(cut_at, $urandom_range(0, 99) < 10, taken);
            sent_total += taken;
        end
    endtask

    // Receiver: the stall level is held for random runs under a style that changes at random
    // intervals, so that some stretches see no stalls at all.
    always @(posedge clk) begin
        if (style_timer == 0) begin
            stall_style <= $urandom_range(0, 2);
            style_timer <= $urandom_range(100, 400);
        end else begin
            style_timer <= style_timer - 1;
        end
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            out_stall <= (stall_style != 0) &&
                         ($urandom_range(0, 99) < ((stall_style == 2) ? 60 : 25));
            stall_hold <= $urandom_range(0, (stall_style == 2) ? 10 : 3);
        end
    end

    // Every output transfer is matched against the oldest prediction, field by field.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_blurs.size() == 0) begin
                $error("unexpected result: row %0d col %0d blurred_level %0d",
                       out_row, out_col, blurred_level);
                fail_count++;
            end else begin
                oldest = pending_blurs.pop_front();
                if (blurred_level !== oldest.blurred) begin
                    $error("blurred_level: expected %0d, actual %0d", oldest.blurred, blurred_level);
                    fail_count++;
                end
                if (out_col !== oldest.col) begin
                    $error("out_col: expected %0d, actual %0d", oldest.col, out_col);
                    fail_count++;
                end
                if (out_row !== oldest.row) begin
                    $error("out_row: expected %0d, actual %0d", oldest.row, out_row);
                    fail_count++;
                end
                if (frame_last !== oldest.last) begin
                    $error("frame_last: expected %0d, actual %0d", oldest.last, frame_last);
                    fail_count++;
                end
            end
        end
    end

    // Any transfer on any channel counts as progress for the watchdog.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("decay_and_box_blur_3x3_core regression: fail");
        $finish;
    end

    initial begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_cases();
        test_size_extremes();
        test_random_frames();

        // Every prediction must have been met; the margin lets a stray extra result show.
        drain_pipeline();
        if (fail_count == 0)
            $display("decay_and_box_blur_3x3_core regression: pass");
        else
            $display("decay_and_box_blur_3x3_core regression: fail");
        $finish;
    end

endmodule

[sim.f]
design/dbb_pkg.sv
design/dbb_track.sv
design/decay_and_box_blur_3x3_core.sv
tb/decay_and_box_blur_3x3_core_tb.sv
